// ===== rtl/core/slxfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slxfr_pkg
// Types and constants shared by the sync / length / xor frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RoleW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  localparam logic [ByteW-1:0] SyncFirstReset  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'h55;

  typedef enum logic [2:0] {
    PH_HUNT1    = 3'd0,
    PH_HUNT2    = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECKSUM = 3'd4
  } phase_t;

  typedef enum logic [RoleW-1:0] {
    ROLE_ID   = 2'd0,
    ROLE_LEN  = 2'd1,
    ROLE_DATA = 2'd2,
    ROLE_PAST = 2'd3
  } role_t;

  typedef enum logic [StatusW-1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_FIRST  = 1'd0,
    REG_SYNC_SECOND = 1'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sync_length_xor_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver_top
// Deframer for sync / sync / length / payload / xor-checksum frames with
// sub-record tagging of each payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

// One input word per cycle: a received byte (tuser 0) or a link timeout
// (tuser 1). The receiver hunts for the two sync bytes, takes the length,
// forwards every payload byte at once tagged with its sub-record role, id and
// data offset, and closes the frame with one end word carrying the checksum
// status (or a timeout status when the link times out inside the payload).
// Each word is decoded into the output register, so the result appears in the
// cycle after acceptance, and a new word is taken every cycle as long as the
// output register is empty or being drained. Sync and length bytes and
// timeouts outside the payload give no output. Sync bytes are written through
// the cfg port; the user must keep this to an idle stream (not enforced).
module sync_length_xor_frame_receiver_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // config write port
  input  wire logic                            cfg_we,
  input  wire logic [slxfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [slxfr_pkg::ByteW-1:0]     cfg_data,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [slxfr_pkg::InDataW-1:0]   s_tdata,  // [7:0] rx_byte
  input  wire logic                            s_tuser,  // [0] cmd
  // output stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] byte_value, [9:8] record_role, [17:10] record_id,
  // [25:18] record_offset, [27:26] frame_status, [31:28] zero
  output logic [slxfr_pkg::OutDataW-1:0]       m_tdata,
  output logic                                 m_tuser   // [0] item_kind
);
  import slxfr_pkg::*;

  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;

  phase_t           phase, phase_next;
  role_t            record_phase, record_phase_next;
  logic [ByteW-1:0] frame_length, frame_length_next;
  logic [ByteW-1:0] payload_count, payload_count_next;
  logic [ByteW-1:0] running_xor, running_xor_next;
  logic [ByteW-1:0] current_record_id, current_record_id_next;
  logic [ByteW-1:0] record_bytes_left, record_bytes_left_next;
  logic [ByteW-1:0] data_offset, data_offset_next;

  logic             out_valid_next;
  logic             out_kind_next;
  logic [ByteW-1:0] out_byte_next;
  role_t            out_role_next;
  logic [ByteW-1:0] out_id_next;
  logic [ByteW-1:0] out_offset_next;
  status_t          out_status_next;

  logic             accept;
  logic [ByteW-1:0] rx_byte;
  logic             stop_point;
  logic [ByteW-1:0] left_dec;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign rx_byte  = s_tdata[ByteW-1:0];
  assign left_dec = record_bytes_left - 8'd1;

  // sub-record end lands past the last full record: consumed + 1 >= length
  assign stop_point = ({2'b00, payload_count} + 10'd2) >= {2'b00, frame_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SyncFirstReset;
      sync_second <= SyncSecondReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next             = phase;
    record_phase_next      = record_phase;
    frame_length_next      = frame_length;
    payload_count_next     = payload_count;
    running_xor_next       = running_xor;
    current_record_id_next = current_record_id;
    record_bytes_left_next = record_bytes_left;
    data_offset_next       = data_offset;
    out_valid_next         = 1'b0;
    out_kind_next          = KIND_PAYLOAD;
    out_byte_next          = '0;
    out_role_next          = ROLE_ID;
    out_id_next            = '0;
    out_offset_next        = '0;
    out_status_next        = ST_GOOD;

    if (s_tuser == CMD_TIMEOUT) begin
      if (phase == PH_PAYLOAD) begin
        out_valid_next  = 1'b1;
        out_kind_next   = KIND_END;
        out_status_next = ST_TIMEOUT;
        phase_next      = PH_HUNT1;
      end
    end else begin
      unique case (phase)
        PH_HUNT1: begin
          if (rx_byte == sync_first) phase_next = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase_next = (rx_byte == sync_second) ? PH_LENGTH : PH_HUNT1;
        end
        PH_LENGTH: begin
          frame_length_next      = rx_byte;
          running_xor_next       = rx_byte;
          payload_count_next     = '0;
          current_record_id_next = '0;
          record_bytes_left_next = '0;
          record_phase_next      = ROLE_ID;
          data_offset_next       = '0;
          phase_next = (rx_byte == '0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          out_valid_next     = 1'b1;
          out_byte_next      = rx_byte;
          out_role_next      = record_phase;
          running_xor_next   = running_xor ^ rx_byte;
          payload_count_next = payload_count + 8'd1;
          if (payload_count + 8'd1 == frame_length) phase_next = PH_CHECKSUM;
          case (record_phase)
            ROLE_ID: begin
              current_record_id_next = rx_byte;
              out_id_next            = rx_byte;
              record_phase_next      = ROLE_LEN;
            end
            ROLE_LEN: begin
              out_id_next            = current_record_id;
              record_bytes_left_next = rx_byte;
              data_offset_next       = '0;
              if (rx_byte == '0) begin
                record_phase_next = stop_point ? ROLE_PAST : ROLE_ID;
              end else begin
                record_phase_next = ROLE_DATA;
              end
            end
            ROLE_DATA: begin
              out_id_next            = current_record_id;
              out_offset_next        = data_offset;
              data_offset_next       = data_offset + 8'd1;
              record_bytes_left_next = left_dec;
              if (left_dec == '0) record_phase_next = stop_point ? ROLE_PAST : ROLE_ID;
            end
            default: ;
          endcase
        end
        PH_CHECKSUM: begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_END;
          out_status_next = (rx_byte == running_xor) ? ST_GOOD : ST_BAD;
          phase_next      = PH_HUNT1;
        end
        default: phase_next = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT1;
      record_phase      <= ROLE_ID;
      frame_length      <= '0;
      payload_count     <= '0;
      running_xor       <= '0;
      current_record_id <= '0;
      record_bytes_left <= '0;
      data_offset       <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      record_phase      <= record_phase_next;
      frame_length      <= frame_length_next;
      payload_count     <= payload_count_next;
      running_xor       <= running_xor_next;
      current_record_id <= current_record_id_next;
      record_bytes_left <= record_bytes_left_next;
      data_offset       <= data_offset_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= out_kind_next;
      m_tdata <= {4'b0000, out_status_next, out_offset_next, out_id_next,
                  out_role_next, out_byte_next};
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync / length / xor frame receiver. A behavioral
// deframer predicts each output word from the accepted input words and the
// sync registers. Directed frames come first, then random frames with sender
// and receiver idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slxfr_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    kind_t       kind;
    logic [7:0]  value;
    role_t       role;
    logic [7:0]  id;
    logic [7:0]  offset;
    status_t     status;
  } frame_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [ByteW-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  // deframer model state
  logic [7:0] sync_a = SyncFirstReset;
  logic [7:0] sync_b = SyncSecondReset;
  phase_t     rx_phase = PH_HUNT1;
  logic [7:0] frm_len = '0;
  logic [7:0] taken = '0;
  logic [7:0] chk_acc = '0;
  logic [7:0] rec_id = '0;
  logic [7:0] rec_left = '0;
  role_t      rec_state = ROLE_ID;
  logic [7:0] rec_off = '0;

  frame_word_t pending_words[$];
  frame_word_t want, got;
  int          words_predicted = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          stall_request = 0;
  int          stall_left = 0;

  sync_length_xor_frame_receiver_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] rx_byte
    .s_tuser   (s_tuser),   // [0] cmd
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] value, [9:8] role, [17:10] id, [25:18] offset,
                            // [27:26] status
    .m_tuser   (m_tuser)    // [0] kind
  );

  always #1 clk = ~clk;

  // returns 1 when the event produces an output word
  function automatic bit deframe_event(input cmd_t c, input logic [7:0] b,
                                       output frame_word_t w);
    bit rec_end;
    rec_end = 1'b0;
    w.kind = KIND_PAYLOAD;
    w.value = '0;
    w.role = ROLE_ID;
    w.id = '0;
    w.offset = '0;
    w.status = ST_GOOD;
    if (c == CMD_TIMEOUT) begin
      if (rx_phase == PH_PAYLOAD) begin
        w.kind = KIND_END;
        w.status = ST_TIMEOUT;
        rx_phase = PH_HUNT1;
        return 1'b1;
      end
      return 1'b0;
    end
    case (rx_phase)
      PH_HUNT1: begin
        if (b == sync_a) rx_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        rx_phase = (b == sync_b) ? PH_LENGTH : PH_HUNT1;
      end
      PH_LENGTH: begin
        frm_len = b;
        chk_acc = b;
        taken = '0;
        rec_id = '0;
        rec_left = '0;
        rec_state = ROLE_ID;
        rec_off = '0;
        rx_phase = (b == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        w.value = b;
        case (rec_state)
          ROLE_ID: begin
            rec_id = b;
            rec_state = ROLE_LEN;
            w.role = ROLE_ID;
            w.id = b;
          end
          ROLE_LEN: begin
            rec_left = b;
            rec_off = '0;
            w.role = ROLE_LEN;
            w.id = rec_id;
            if (b == 8'd0) rec_end = 1'b1;
            else rec_state = ROLE_DATA;
          end
          ROLE_DATA: begin
            w.role = ROLE_DATA;
            w.id = rec_id;
            w.offset = rec_off;
            rec_off = rec_off + 8'd1;
            rec_left = rec_left - 8'd1;
            rec_end = (rec_left == 8'd0);
          end
          default: begin
            w.role = ROLE_PAST;
          end
        endcase
        // tagging stops once the bytes taken reach length - 1
        if (rec_end) rec_state = (int'(taken) + 2 >= int'(frm_len)) ? ROLE_PAST : ROLE_ID;
        chk_acc = chk_acc ^ b;
        taken = taken + 8'd1;
        if (taken == frm_len) rx_phase = PH_CHECKSUM;
        return 1'b1;
      end
      PH_CHECKSUM: begin
        w.kind = KIND_END;
        w.status = (b == chk_acc) ? ST_GOOD : ST_BAD;
        rx_phase = PH_HUNT1;
        return 1'b1;
      end
      default: rx_phase = PH_HUNT1;
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val,
                                      int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // predict first, then check, so a same-edge push never meets an empty queue
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (deframe_event(cmd_t'(s_tuser), s_tdata, want)) begin
          pending_words.push_back(want);
          words_predicted++;
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          $error("output word 0x%0h / kind %0d with nothing expected", m_tdata, m_tuser);
          mismatches++;
        end else begin
          got = pending_words.pop_front();
          check_field("item_kind", got.kind, m_tuser);
          check_field("byte_value", got.value, m_tdata[7:0]);
          check_field("record_role", got.role, m_tdata[9:8]);
          check_field("record_id", got.id, m_tdata[17:10]);
          check_field("record_offset", got.offset, m_tdata[25:18]);
          check_field("frame_status", got.status, m_tdata[27:26]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input cmd_t c, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(CMD_BYTE, b);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    cfg_we <= 1'b1;
    cfg_index <= REG_SYNC_FIRST;
    cfg_data <= first;
    @(negedge clk);
    cfg_index <= REG_SYNC_SECOND;
    cfg_data <= second;
    @(negedge clk);
    cfg_we <= 1'b0;
    sync_a = first;
    sync_b = second;
  endtask

  task automatic send_random_frame(input int max_len);
    int         len;
    int         cut;
    int         rlen;
    int         r;
    logic [7:0] body[$];
    logic [7:0] sum;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 3))
        send_word(cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end else if (r < 18) begin
      send_byte(sync_a);
      send_byte(~sync_b);
    end
    send_byte(sync_a);
    if ($urandom_range(0, 99) < 4) send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
    send_byte(sync_b);
    r = $urandom_range(0, 99);
    if (r < 2) len = max_len;
    else if (r < 10) len = 0;
    else if (r < 20) len = $urandom_range(21, 80);
    else len = $urandom_range(1, 20);
    // chain of sub-records, some running past the payload
    while (body.size() < len) begin
      body.push_back(8'($urandom_range(0, 255)));
      rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
      body.push_back(8'(rlen));
      repeat (rlen) body.push_back(8'($urandom_range(0, 255)));
    end
    while (body.size() > len) void'(body.pop_back());
    cut = (len > 0 && $urandom_range(0, 99) < 7) ? $urandom_range(0, len - 1) : -1;
    send_byte(8'(len));
    sum = 8'(len);
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
        return;
      end
      send_byte(body[i]);
      sum = sum ^ body[i];
    end
    if ($urandom_range(0, 99) < 12) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // timeouts outside the payload, zero-length frame
  task automatic test_ignored_events();
    send_word(CMD_TIMEOUT, 8'hFF);
    send_byte(8'hAA);
    send_word(CMD_TIMEOUT, 8'h00);
    send_byte(8'h55);
    send_byte(8'h00);
    send_word(CMD_TIMEOUT, 8'h5A);
    send_byte(8'h00);
  endtask

  // two records, the second with zero length, then a byte past the records
  task automatic test_record_tags();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h06);
    send_byte(8'h12);
    send_byte(8'h01);
    send_byte(8'hA0);
    send_byte(8'h34);
    send_byte(8'h00);
    send_byte(8'h5B);
    send_byte(8'hDA);
  endtask

  // record longer than the payload, closed by a wrong checksum
  task automatic test_overlong_record();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h04);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  task automatic test_payload_timeout();
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h03);
    send_byte(8'h01);
    send_word(CMD_TIMEOUT, 8'h80);
  endtask

  // the failing second byte is dropped, so the following 0x55 finds nothing
  task automatic test_sync_loss();
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'h7E);
    send_byte(8'h7F);
  endtask

  task automatic run_traffic(input int goal, input int send_pct, input int recv_pct);
    int start;
    start = words_predicted;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (words_predicted - start < goal) send_random_frame(255);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_traffic(110, 0, 0);
    set_sync(8'h00, 8'hFF);
    run_traffic(110, 81, 0);
    set_sync(8'hFF, 8'h00);
    run_traffic(110, 0, 81);
    set_sync(8'h5A, 8'h5A);
    run_traffic(110, 81, 81);
    set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_traffic(100, 16, 16);
  endtask

  // output held off while the sender keeps pushing, then a full drain
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_request = 300;
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'd60);
    repeat (60) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    wait_idle();
    set_sync(SyncFirstReset, SyncSecondReset);
    repeat (3) send_random_frame(40);
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_ignored_events();
    test_record_tags();
    test_overlong_record();
    test_payload_timeout();
    test_sync_loss();
    wait_idle();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sync_length_xor_frame_receiver_top.f =====
rtl/core/slxfr_pkg.sv
rtl/core/sync_length_xor_frame_receiver_top.sv
bench/tb.sv
